[src/vmt_pkg.sv]
// shared types, widths, register map and reset values for the vertex matrix transform
`default_nettype none
package vmt_pkg;

  localparam int unsigned FRAC_BITS_DEF = 12;
  localparam int unsigned COORD_W       = 16;
  localparam int unsigned NUM_LANES     = 4;
  localparam int unsigned ROW_W         = NUM_LANES * COORD_W;
  localparam int unsigned PROD_W        = 2 * COORD_W;
  localparam int unsigned SUM_W         = PROD_W + 2;
  localparam int unsigned OUT_W         = 22;
  localparam int unsigned COMP_W        = 3;
  localparam int unsigned DATA_W        = 64;
  localparam int unsigned ADDR_W        = 6;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [NUM_LANES-1:0][COORD_W-1:0] point_t;

  // register map, one 64-bit register every 8 bytes
  typedef enum logic [2:0] {
    REG_ROW_X      = 3'd0,
    REG_ROW_Y      = 3'd1,
    REG_ROW_Z      = 3'd2,
    REG_ROW_W      = 3'd3,
    REG_COMPONENTS = 3'd4,
    REG_PROJECTIVE = 3'd5
  } reg_idx_t;

  localparam logic [COMP_W-1:0] COMP_TWO   = 3'd2;
  localparam logic [COMP_W-1:0] COMP_THREE = 3'd3;
  localparam logic [COMP_W-1:0] COMP_FOUR  = 3'd4;

  // identity matrix, one Q4.12 unit on the diagonal
  localparam row_t ROW_X_RST = 64'h0000_0000_0000_1000;
  localparam row_t ROW_Y_RST = 64'h0000_0000_1000_0000;
  localparam row_t ROW_Z_RST = 64'h0000_1000_0000_0000;
  localparam row_t ROW_W_RST = 64'h1000_0000_0000_0000;
  localparam logic [COMP_W-1:0] COMP_RST = COMP_THREE;

  // load strobes for the two lane pipeline stages
  typedef struct packed {
    logic load_mul;
    logic load_sum;
  } stage_ctl_t;

endpackage
`default_nettype wire

[src/vmt_lane.sv]
// one matrix row lane: four registered products, then sum and arithmetic shift
`default_nettype none
module vmt_lane #(
  parameter int unsigned FRAC_BITS = vmt_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  vmt_pkg::stage_ctl_t                ctl,
  input  vmt_pkg::row_t                      row,
  input  vmt_pkg::point_t                    point,
  output logic signed [vmt_pkg::OUT_W-1:0]   result
);
  import vmt_pkg::*;

  logic signed [PROD_W-1:0] prod [NUM_LANES];
  logic signed [SUM_W-1:0]  sum_c;
  logic signed [SUM_W-1:0]  shifted;

  always_ff @(posedge clk) begin
    if (ctl.load_mul) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        prod[k] <= $signed(row[k*COORD_W +: COORD_W]) * $signed(point[k]);
      end
    end
  end

  always_comb begin
    sum_c = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      sum_c = sum_c + $signed({{(SUM_W-PROD_W){prod[k][PROD_W-1]}}, prod[k]});
    end
    // arithmetic shift rounds toward minus infinity
    shifted = sum_c >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (ctl.load_sum) begin
      result <= shifted[OUT_W-1:0];
    end
  end

endmodule
`default_nettype wire

[src/vertex_matrix_transform_top.sv]
// top level: register file, four row lanes, handshake pipeline and result merge
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  input    | in        | in_valid/in_ready  | coord_x, coord_y, coord_z, coord_w, last_point
//  output   | out       | out_valid/out_ready| out_x, out_y, out_z, out_w, batch_end, refused
//  config   | in/out    | apb psel/penable   | paddr, pwdata, prdata, pready (always high)
//
// one request per cycle sustained while results are taken; out_valid rises as stage 2 loads
// stage 1 registers the sixteen 16x16 products (four per lane), stage 2 the sums
// stage 2 is the output register, so stage 1 can take a request while a result waits
// reset is synchronous and clears the pipeline valids and loads the identity matrix
// a stalled output holds the result; input backs up only when both stages are full and the result is not taken
`default_nettype none
module vertex_matrix_transform_top #(
  parameter int unsigned FRAC_BITS = vmt_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // input requests
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [vmt_pkg::COORD_W-1:0] coord_x,
  input  logic signed [vmt_pkg::COORD_W-1:0] coord_y,
  input  logic signed [vmt_pkg::COORD_W-1:0] coord_z,
  input  logic signed [vmt_pkg::COORD_W-1:0] coord_w,
  input  logic                               last_point,
  // results
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [vmt_pkg::OUT_W-1:0]   out_x,
  output logic signed [vmt_pkg::OUT_W-1:0]   out_y,
  output logic signed [vmt_pkg::OUT_W-1:0]   out_z,
  output logic signed [vmt_pkg::OUT_W-1:0]   out_w,
  output logic                               batch_end,
  output logic                               refused,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vmt_pkg::ADDR_W-1:0]         paddr,
  input  logic [vmt_pkg::DATA_W-1:0]         pwdata,
  output logic [vmt_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import vmt_pkg::*;

  // configuration registers
  row_t              row_x;
  row_t              row_y;
  row_t              row_z;
  row_t              row_w;
  logic [COMP_W-1:0] components_used;
  logic              projective;

  logic              cfg_write;
  logic [2:0]        reg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = paddr[ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x           <= ROW_X_RST;
      row_y           <= ROW_Y_RST;
      row_z           <= ROW_Z_RST;
      row_w           <= ROW_W_RST;
      components_used <= COMP_RST;
      projective      <= 1'b0;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_ROW_X:      row_x           <= pwdata;
        REG_ROW_Y:      row_y           <= pwdata;
        REG_ROW_Z:      row_z           <= pwdata;
        REG_ROW_W:      row_w           <= pwdata;
        REG_COMPONENTS: components_used <= pwdata[COMP_W-1:0];
        REG_PROJECTIVE: projective      <= pwdata[0];
        default: ;  // unmapped addresses are ignored
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ROW_X:      prdata = row_x;
      REG_ROW_Y:      prdata = row_y;
      REG_ROW_Z:      prdata = row_z;
      REG_ROW_W:      prdata = row_w;
      REG_COMPONENTS: prdata = {{(DATA_W-COMP_W){1'b0}}, components_used};
      REG_PROJECTIVE: prdata = {{(DATA_W-1){1'b0}}, projective};
      default:        prdata = '0;
    endcase
  end

  // request decode: fill in missing coordinates, check the mode
  point_t point;
  logic   mode_ok;

  always_comb begin
    mode_ok = (components_used inside {COMP_TWO, COMP_THREE}) ||
              ((components_used == COMP_FOUR) && projective);
    point[0] = coord_x;
    point[1] = coord_y;
    // z is zero for two-component points
    point[2] = (components_used == COMP_TWO) ? '0 : coord_z;
    // w is one unless the point carries it
    point[3] = (components_used == COMP_FOUR) ? coord_w : COORD_W'(1);
  end

  // two-stage pipeline with per-stage valid so bubbles collapse
  logic       v1;
  logic       last1;
  logic       refused1;
  logic       proj1;
  logic       ready2;
  logic       proj2;
  logic       accept_in;
  stage_ctl_t ctl;

  assign ready2       = !out_valid || out_ready;
  assign in_ready     = !v1 || ready2;
  assign accept_in    = in_valid && in_ready;
  assign ctl.load_mul = accept_in;
  assign ctl.load_sum = v1 && ready2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept_in) begin
        v1 <= 1'b1;
      end else if (ready2) begin
        v1 <= 1'b0;
      end
      if (ctl.load_sum) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // side information travels alongside the lanes, no reset needed
  always_ff @(posedge clk) begin
    if (accept_in) begin
      last1    <= last_point;
      refused1 <= !mode_ok;
      proj1    <= projective;
    end
    if (ctl.load_sum) begin
      batch_end <= last1;
      refused   <= refused1;
      proj2     <= proj1;
    end
  end

  // one lane per matrix row
  logic signed [OUT_W-1:0] lane_res [NUM_LANES];
  row_t                    rows     [NUM_LANES];

  assign rows[0] = row_x;
  assign rows[1] = row_y;
  assign rows[2] = row_z;
  assign rows[3] = row_w;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    vmt_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .ctl   (ctl),
      .row   (rows[g]),
      .point (point),
      .result(lane_res[g])
    );
  end

  // merge: refused requests read zero, w reads zero outside projective mode
  assign out_x = refused ? '0 : lane_res[0];
  assign out_y = refused ? '0 : lane_res[1];
  assign out_z = refused ? '0 : lane_res[2];
  assign out_w = (refused || !proj2) ? '0 : lane_res[3];

  // input only backs up when the output holds a result that is not taken
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v1 && out_valid && !out_ready))
    else $error("input stalled with a free pipeline slot");

  // an accepted request always occupies stage 1 next cycle
  a_stage1_fill: assert property (@(posedge clk) disable iff (rst)
    accept_in |=> v1)
    else $error("accepted request lost before stage 1");

  // stage 1 drains into the output register when it has room
  a_stage2_fill: assert property (@(posedge clk) disable iff (rst)
    (v1 && ready2) |=> out_valid)
    else $error("stage 1 request not moved to output");

  // a refused result carries only zeros
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && refused) |-> (out_x == '0 && out_y == '0 && out_z == '0 && out_w == '0))
    else $error("refused result carries data");

  // a result still waiting keeps its side information
  a_hold_meta: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(batch_end) && $stable(refused) && $stable(proj2)))
    else $error("waiting result changed");

endmodule
`default_nettype wire

[dv/vmt_checker.sv]
`timescale 1ns / 1ps
// scoreboard for the vertex matrix transform: tracks registers, predicts and compares results
module vmt_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [vmt_pkg::COORD_W-1:0] coord_x,
  input  logic signed [vmt_pkg::COORD_W-1:0] coord_y,
  input  logic signed [vmt_pkg::COORD_W-1:0] coord_z,
  input  logic signed [vmt_pkg::COORD_W-1:0] coord_w,
  input  logic                               last_point,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [vmt_pkg::OUT_W-1:0]   out_x,
  input  logic signed [vmt_pkg::OUT_W-1:0]   out_y,
  input  logic signed [vmt_pkg::OUT_W-1:0]   out_z,
  input  logic signed [vmt_pkg::OUT_W-1:0]   out_w,
  input  logic                               batch_end,
  input  logic                               refused,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vmt_pkg::ADDR_W-1:0]         paddr,
  input  logic [vmt_pkg::DATA_W-1:0]         pwdata,
  input  logic                               pready,
  output int                                 fails,
  output int                                 pending,
  output int                                 results_checked,
  output int                                 refusals
);
  import vmt_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int ACC_W = 48;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic signed [OUT_W-1:0] w;
    logic                    batch_end;
    logic                    refused;
  } vertex_result_t;

  // shadow copy of the register file
  row_t              mat [NUM_LANES];
  logic [COMP_W-1:0] comp_cnt;
  logic              proj_mode;

  vertex_result_t expected_vertices [$];
  vertex_result_t want;
  vertex_result_t got;

  // one row dotted with the point, floor-shifted out of Q4.12
  function automatic logic signed [OUT_W-1:0] dot_row(input row_t row, input point_t pt);
    logic signed [ACC_W-1:0] acc;
    int k;
    acc = '0;
    for (k = 0; k < NUM_LANES; k++)
      acc = acc + $signed(row[COORD_W*k +: COORD_W]) * $signed(pt[k]);
    acc = acc >>> FRAC;
    return acc[OUT_W-1:0];
  endfunction

  function automatic vertex_result_t predict_vertex(input logic [COORD_W-1:0] cx,
                                                    input logic [COORD_W-1:0] cy,
                                                    input logic [COORD_W-1:0] cz,
                                                    input logic [COORD_W-1:0] cw,
                                                    input logic last);
    vertex_result_t r;
    point_t pt;
    bit accepted;
    accepted = (comp_cnt == COMP_TWO) || (comp_cnt == COMP_THREE) ||
               (comp_cnt == COMP_FOUR && proj_mode);
    r = '0;
    r.batch_end = last;
    if (!accepted) begin
      r.refused = 1'b1;
      return r;
    end
    pt[0] = cx;
    pt[1] = cy;
    pt[2] = (comp_cnt == COMP_TWO) ? '0 : cz;
    pt[3] = (comp_cnt == COMP_FOUR) ? cw : COORD_W'(1);
    r.x = dot_row(mat[0], pt);
    r.y = dot_row(mat[1], pt);
    r.z = dot_row(mat[2], pt);
    r.w = proj_mode ? dot_row(mat[3], pt) : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mat[0] = ROW_X_RST;
      mat[1] = ROW_Y_RST;
      mat[2] = ROW_Z_RST;
      mat[3] = ROW_W_RST;
      comp_cnt = COMP_RST;
      proj_mode = 1'b0;
      expected_vertices.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.x = out_x;
        got.y = out_y;
        got.z = out_z;
        got.w = out_w;
        got.batch_end = batch_end;
        got.refused = refused;
        if (expected_vertices.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result with no request pending: x=%0d y=%0d z=%0d w=%0d",
                     $realtime, got.x, got.y, got.z, got.w);
        end else begin
          want = expected_vertices.pop_front();
          results_checked++;
          if (want.refused) refusals++;
          if (got !== want) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: mismatch, exp x=%0d y=%0d z=%0d w=%0d end=%0b refused=%0b",
                       $realtime, want.x, want.y, want.z, want.w, want.batch_end,
                       want.refused);
              $display("           got x=%0d y=%0d z=%0d w=%0d end=%0b refused=%0b",
                       got.x, got.y, got.z, got.w, got.batch_end, got.refused);
            end
          end
        end
      end
      if (in_valid && in_ready)
        expected_vertices.push_back(predict_vertex(coord_x, coord_y, coord_z, coord_w,
                                                   last_point));
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:3]))
          REG_ROW_X:      mat[0] = pwdata;
          REG_ROW_Y:      mat[1] = pwdata;
          REG_ROW_Z:      mat[2] = pwdata;
          REG_ROW_W:      mat[3] = pwdata;
          REG_COMPONENTS: comp_cnt = pwdata[COMP_W-1:0];
          REG_PROJECTIVE: proj_mode = pwdata[0];
          default: ;
        endcase
      end
    end
    pending = expected_vertices.size();
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// testbench top: clock, reset, point and register stimulus, final verdict
module tb_top;
  import vmt_pkg::*;

  localparam int IDLE_PCT       = 35;   // share of cycles each side sits idle
  localparam int RAND_SEGMENTS  = 14;   // one matrix and mode setting per segment
  localparam int SEGMENT_POINTS = 100;
  localparam int QUIET_SEGMENT  = 5;    // segment run with no idling on either side

  logic clk = 1'b0;
  logic rst = 1'b1;

  // request channel
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic signed [COORD_W-1:0] coord_z = '0;
  logic signed [COORD_W-1:0] coord_w = '0;
  logic                      last_point = 1'b0;

  // result channel
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [OUT_W-1:0]   out_x;
  logic signed [OUT_W-1:0]   out_y;
  logic signed [OUT_W-1:0]   out_z;
  logic signed [OUT_W-1:0]   out_w;
  logic                      batch_end;
  logic                      refused;

  // register port
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  // scoreboard status
  int fails;
  int pending;
  int results_checked;
  int refusals;

  bit pacing = 1'b1;      // random idling on both sides when set
  int settings_used;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  vertex_matrix_transform_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .coord_w    (coord_w),
    .last_point (last_point),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .out_w      (out_w),
    .batch_end  (batch_end),
    .refused    (refused),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  vmt_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .coord_x         (coord_x),
    .coord_y         (coord_y),
    .coord_z         (coord_z),
    .coord_w         (coord_w),
    .last_point      (last_point),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_z           (out_z),
    .out_w           (out_w),
    .batch_end       (batch_end),
    .refused         (refused),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .fails           (fails),
    .pending         (pending),
    .results_checked (results_checked),
    .refusals        (refusals)
  );

  // result side back-pressure, off during the quiet stretch
  always @(posedge clk) begin
    out_ready <= !pacing || ($urandom_range(99) >= IDLE_PCT);
  end

  // biased coordinate: extremes, zero and small values show up often
  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return COORD_W'($urandom_range(16) - 8);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // biased Q4.12 row: lanes often at -8.0, just under 8.0, zero, one or minus one
  function automatic row_t rand_row();
    row_t row;
    int k;
    for (k = 0; k < NUM_LANES; k++) begin
      case ($urandom_range(9))
        0: row[COORD_W*k +: COORD_W] = 16'h8000;
        1: row[COORD_W*k +: COORD_W] = 16'h7fff;
        2: row[COORD_W*k +: COORD_W] = 16'h0000;
        3: row[COORD_W*k +: COORD_W] = 16'h1000;
        4: row[COORD_W*k +: COORD_W] = 16'hf000;
        default: row[COORD_W*k +: COORD_W] = COORD_W'($urandom);
      endcase
    end
    return row;
  endfunction

  // setup cycle, access cycle, then the port is released
  task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_matrix(input row_t rx, input row_t ry, input row_t rz, input row_t rw);
    apb_write(REG_ROW_X, rx);
    apb_write(REG_ROW_Y, ry);
    apb_write(REG_ROW_Z, rz);
    apb_write(REG_ROW_W, rw);
  endtask

  // noisy writes put random junk above the used bits of the mode registers
  task automatic set_mode(input logic [COMP_W-1:0] comp, input bit proj, input bit noisy);
    logic [DATA_W-1:0] v;
    v = noisy ? {$urandom, $urandom} : '0;
    v[COMP_W-1:0] = comp;
    apb_write(REG_COMPONENTS, v);
    v = noisy ? {$urandom, $urandom} : '0;
    v[0] = proj;
    apb_write(REG_PROJECTIVE, v);
    settings_used++;
  endtask

  // stop requests, wait for every result, then let the two-stage pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one request; in_valid stays high afterward unless the next call idles first
  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [COORD_W-1:0] z, input logic [COORD_W-1:0] w,
                            input logic last);
    while (pacing && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    coord_x    <= x;
    coord_y    <= y;
    coord_z    <= z;
    coord_w    <= w;
    last_point <= last;
    // in_ready is settled by mid-cycle, so the accepting edge is known without a race
    @(negedge clk);
    while (!in_ready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  initial begin : stimulus
    int seg;
    int n;
    int guard;
    logic [COMP_W-1:0] comp;
    bit proj;
    row_t rows [NUM_LANES];

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity matrix out of reset, three components, transform mode
    send_point(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_point(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    send_point(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_point(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 1'b0);

    // every coefficient at -8.0: all-minimum point gives the largest magnitude, 2^20
    drain();
    set_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
    set_mode(COMP_FOUR, 1'b1, 1'b0);
    send_point(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_point(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    send_point(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 1'b1);

    // every coefficient just under 8.0
    drain();
    set_matrix({4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}});
    send_point(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_point(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1);

    // four components in transform mode must be refused, batch flag still copied
    drain();
    set_mode(COMP_FOUR, 1'b0, 1'b0);
    send_point(16'h1234, 16'h8000, 16'h7fff, 16'hffff, 1'b1);
    send_point(16'h7fff, 16'h0001, 16'h8000, 16'h4321, 1'b0);

    // two components: z and w inputs must be ignored
    drain();
    set_matrix(rand_row(), rand_row(), rand_row(), rand_row());
    set_mode(COMP_TWO, 1'b1, 1'b0);
    send_point(16'h0100, 16'hff00, 16'h7fff, 16'h8000, 1'b0);
    send_point(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b1);
    send_point(rand_coord(), rand_coord(), 16'h5555, 16'haaaa, 1'b0);

    // tiny sums around zero: the shift rounds toward minus infinity
    drain();
    set_matrix(64'h0000_0000_0000_0001, 64'h0000_0000_0000_ffff,
               64'h0000_0000_0001_0000, 64'hf800_0000_0000_0000);
    set_mode(COMP_THREE, 1'b1, 1'b0);
    send_point(16'hffff, 16'h0001, 16'h0000, 16'h0000, 1'b0);
    send_point(16'h0001, 16'hffff, 16'h0003, 16'h0000, 1'b1);

    // component counts outside two to four are refused in either mode
    drain();
    set_mode(3'd0, 1'b1, 1'b0);
    send_point(16'h0101, 16'h0202, 16'h0303, 16'h0404, 1'b1);
    drain();
    set_mode(3'd1, 1'b0, 1'b0);
    send_point(16'h0101, 16'h0202, 16'h0303, 16'h0404, 1'b0);
    drain();
    set_mode(3'd5, 1'b1, 1'b0);
    send_point(16'h8000, 16'h7fff, 16'h0303, 16'h0404, 1'b1);
    drain();
    set_mode(3'd6, 1'b0, 1'b0);
    send_point(16'h7fff, 16'h8000, 16'h0303, 16'h0404, 1'b0);
    drain();
    set_mode(3'd7, 1'b1, 1'b0);
    send_point(16'hffff, 16'h0000, 16'hffff, 16'h0000, 1'b1);

    // random segments: a fresh matrix and mode each, mostly accepted settings
    for (seg = 0; seg < RAND_SEGMENTS; seg++) begin
      drain();
      for (n = 0; n < NUM_LANES; n++) begin
        case (seg)
          1: rows[n] = {4{16'h8000}};
          2: rows[n] = {4{16'h7fff}};
          3: rows[n] = {4{16'hffff}};
          default: rows[n] = rand_row();
        endcase
      end
      set_matrix(rows[0], rows[1], rows[2], rows[3]);
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5:       comp = COMP_TWO;
        6, 7, 8, 9, 10, 11:     comp = COMP_THREE;
        12, 13, 14, 15, 16, 17: comp = COMP_FOUR;
        default:                comp = COMP_W'($urandom_range(7));
      endcase
      // four components are mostly paired with projective mode so they get through
      proj = (comp == COMP_FOUR) ? ($urandom_range(4) != 0) : 1'($urandom_range(1));
      if (seg == 1 || seg == 2) begin
        comp = COMP_FOUR;
        proj = 1'b1;
      end
      set_mode(comp, proj, 1'b1);
      pacing = (seg != QUIET_SEGMENT);
      for (n = 0; n < SEGMENT_POINTS; n++)
        send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   $urandom_range(7) == 0);
    end
    pacing = 1'b1;

    // wait out the outstanding results, bounded, then the pipeline latency
    in_valid <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 10000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);

    if (pending != 0)
      $display("%0d expected results never arrived", pending);
    $display("checked %0d results (%0d refused) over %0d mode settings,", results_checked,
             refusals, settings_used);
    $display("identity, extreme and random matrices, two to four components and bad counts");
    if (fails == 0 && pending == 0) begin
      $display("** vertex_matrix_transform_top: PASSED **");
    end else begin
      $display("** vertex_matrix_transform_top: FAILED **");
    end
    $finish;
  end

  // run guard, far beyond the slowest correct run
  initial begin : watchdog
    #2000000;
    $display("timeout with %0d results outstanding", pending);
    $display("** vertex_matrix_transform_top: FAILED **");
    $finish;
  end

endmodule
